### rtl/ppm_see_pkg.sv
package ppm_see_pkg;

  localparam int ROWS          = 44;
  localparam int COLS          = 8;
  localparam int ENTRIES       = ROWS * COLS;
  localparam int ROW_W         = $clog2(ROWS);
  localparam int COL_W         = $clog2(COLS);
  localparam int ENTRY_W       = ROW_W + COL_W;
  localparam int MAX_SHIFT_DEF = 7;

  localparam logic [ROW_W-1:0]   LAST_ROW      = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]   LAST_COL      = COL_W'(COLS - 1);
  localparam logic [ENTRY_W-1:0] RESERVED_ENTRY = ENTRY_W'((ROWS - 1) * COLS);
  localparam logic [3:0]         TF_FACTOR     = 4'd11;
  localparam logic [8:0]         FULL_ALPHABET = 9'd256;

  localparam logic [1:0] FUNC_QUERY  = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_REINIT = 2'd2;

  typedef struct packed {
    logic [15:0] sum;
    logic [3:0]  shift;
    logic [7:0]  count;
  } ctx_t;

  typedef struct packed {
    logic capture;
    logic sweep_wr;
    logic exec;
  } see_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } see_sts_t;

  // Row bucket of diff-1, with diff clamped to 1..256.
  function automatic logic [ROW_W-1:0] diff_bucket(input logic [8:0] d);
    logic [7:0] i;
    logic [7:0] t;
    if (d == 9'd0) begin
      i = 8'd0;
    end else if (d > FULL_ALPHABET) begin
      i = 8'd255;
    end else begin
      i = 8'(d - 9'd1);
    end
    if (i < 8'd4) begin
      t = i;
    end else if (i < 8'd12) begin
      t = 8'd4 + ((i - 8'd4) >> 1);
    end else if (i < 8'd44) begin
      t = 8'd8 + ((i - 8'd12) >> 2);
    end else begin
      t = 8'd16 + ((i - 8'd44) >> 3);
    end
    return t[ROW_W-1:0];
  endfunction

endpackage

### rtl/ppm_see_ctrl.sv
module ppm_see_ctrl
  import ppm_see_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] func,
  input  see_sts_t   sts,
  output logic       in_stall,
  output see_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state, state_next;
  logic   report, report_next;

  always_comb begin
    state_next  = state;
    report_next = report;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (func == FUNC_REINIT) begin
            state_next  = S_SWEEP;
            report_next = 1'b1;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_next  = report ? S_EXEC : S_IDLE;
          report_next = 1'b0;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Reset starts with a sweep that loads the table and reports nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_SWEEP;
      report <= 1'b0;
    end else begin
      state  <= state_next;
      report <= report_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

### rtl/ppm_see_dp.sv
module ppm_see_dp
  import ppm_see_pkg::*;
#(
  parameter int MAX_SHIFT = MAX_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  see_cmd_t    cmd,
  input  logic [1:0]  func,
  input  logic [8:0]  symbol_count,
  input  logic [8:0]  parent_symbol_count,
  input  logic [15:0] total_freq,
  input  logic [8:0]  diff,
  input  logic [8:0]  masked_count,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [15:0] escape_mean,
  output see_sts_t    sts
);

  localparam logic [3:0] INIT_SHIFT  = 4'(MAX_SHIFT - 3);
  localparam logic [4:0] SHIFT_LIMIT = 5'(MAX_SHIFT);

  ctx_t mem [ENTRIES];
  ctx_t rd_q;

  logic [ENTRY_W-1:0] last_used;
  logic [ENTRY_W-1:0] addr_q;
  logic [1:0]         func_q;
  logic               reserved_q;
  logic [ROW_W-1:0]   sweep_row;
  logic [COL_W-1:0]   sweep_col;

  // Context selection from the item's statistics.
  logic               full_alpha;
  logic               col_hi, col_mid, col_lo;
  logic [8:0]         psc_gap;
  logic [12:0]        tf_limit;
  logic [ENTRY_W-1:0] query_entry;
  logic [ENTRY_W-1:0] rd_addr;

  always_comb begin
    full_alpha  = (symbol_count == FULL_ALPHABET);
    psc_gap     = parent_symbol_count - symbol_count;
    col_hi      = (parent_symbol_count < symbol_count) || (diff < psc_gap);
    tf_limit    = 13'(symbol_count) * 13'(TF_FACTOR);
    col_mid     = (total_freq < 16'(tf_limit));
    col_lo      = (masked_count > diff);
    query_entry = {diff_bucket(diff), col_hi, col_mid, col_lo};
    rd_addr     = (func == FUNC_QUERY && !full_alpha) ? query_entry : last_used;
  end

  // Arithmetic on the context read back from the table.
  logic [15:0]  mean;
  logic [3:0]   shift_inc;
  logic [15:0]  count_full;
  logic [7:0]   count_dec;
  ctx_t         query_ctx, update_ctx;
  logic         update_live;
  logic [15:0]  result;
  logic [31:0]  init_sum;
  ctx_t         init_ctx;

  always_comb begin
    mean       = rd_q.sum >> rd_q.shift;
    shift_inc  = rd_q.shift + 4'd1;
    count_full = 16'd2 << shift_inc;
    count_dec  = rd_q.count - 8'd1;

    query_ctx       = rd_q;
    query_ctx.sum   = rd_q.sum - mean;

    update_live = (32'(addr_q) < 32'(ENTRIES)) && ({1'b0, rd_q.shift} < SHIFT_LIMIT);
    update_ctx  = rd_q;
    if (count_dec == 8'd0) begin
      update_ctx.sum   = {rd_q.sum[14:0], 1'b0};
      update_ctx.shift = shift_inc;
      update_ctx.count = count_full[7:0];
    end else begin
      update_ctx.count = count_dec;
    end

    if (func_q == FUNC_QUERY) begin
      result = (reserved_q || mean == 16'd0) ? 16'd1 : mean;
    end else begin
      result = 16'd0;
    end

    init_sum       = (32'({sweep_row, 2'b00}) + 32'd8) << INIT_SHIFT;
    init_ctx.sum   = init_sum[15:0];
    init_ctx.shift = INIT_SHIFT;
    init_ctx.count = 8'd16;
  end

  // Table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      mem[{sweep_row, sweep_col}] <= init_ctx;
    end else if (cmd.exec && func_q == FUNC_QUERY && !reserved_q) begin
      mem[addr_q] <= query_ctx;
    end else if (cmd.exec && func_q == FUNC_UPDATE && update_live) begin
      mem[addr_q] <= update_ctx;
    end
    if (cmd.capture) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q     <= rd_addr;
      func_q     <= func;
      reserved_q <= full_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_used <= RESERVED_ENTRY;
      sweep_row <= '0;
      sweep_col <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture && func == FUNC_QUERY) begin
        last_used <= full_alpha ? RESERVED_ENTRY : query_entry;
      end
      if (cmd.sweep_wr) begin
        if (sweep_col == LAST_COL) begin
          sweep_col <= '0;
          sweep_row <= (sweep_row == LAST_ROW) ? '0 : sweep_row + 1'b1;
        end else begin
          sweep_col <= sweep_col + 1'b1;
        end
      end
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      escape_mean <= result;
    end
  end

  assign sts.sweep_last = (sweep_row == LAST_ROW) && (sweep_col == LAST_COL);
  assign sts.out_free   = !out_valid || !out_stall;

  a_exec_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("result not presented after execution");

  a_last_in_table: assert property (@(posedge clk) disable iff (rst)
    32'(last_used) < 32'(ENTRIES))
    else $error("last used context outside the table");

  a_sweep_row: assert property (@(posedge clk) disable iff (rst)
    sweep_row <= LAST_ROW)
    else $error("sweep row past the last row");

  a_no_capture_in_sweep: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.sweep_wr))
    else $error("item captured during a sweep");

endmodule

### rtl/ppm_escape_estimator_table.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// in       | input     | in_valid/in_stall  | func, symbol_count, parent_symbol_count,
//          |           |                    | total_freq, diff, masked_count
// out      | output    | out_valid/out_stall| escape_mean
//
// A query or update is captured while idle, which reads the context table; in the
// exec state it writes the context back and loads the result register. A reinit
// sweeps all 352 contexts, one a cycle, and then presents its result. After rst a
// sweep of all 352 contexts loads the table, with in_stall high throughout. An item
// is taken while the previous result still waits; a held result stalls the next
// item only at write-back.
module ppm_escape_estimator_table
  import ppm_see_pkg::*;
#(
  parameter int MAX_SHIFT = MAX_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [8:0]  symbol_count,
  input  logic [8:0]  parent_symbol_count,
  input  logic [15:0] total_freq,
  input  logic [8:0]  diff,
  input  logic [8:0]  masked_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] escape_mean
);

  see_cmd_t cmd;
  see_sts_t sts;

  // Sequence the table: load sweep, capture, write-back.
  ppm_see_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Hold the context table, its arithmetic and the result register.
  ppm_see_dp #(
    .MAX_SHIFT (MAX_SHIFT)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .func                (func),
    .symbol_count        (symbol_count),
    .parent_symbol_count (parent_symbol_count),
    .total_freq          (total_freq),
    .diff                (diff),
    .masked_count        (masked_count),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .escape_mean         (escape_mean),
    .sts                 (sts)
  );

endmodule

### tb/escape_mean_checker.sv
module escape_mean_checker
  import ppm_see_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  func,
  input  logic [8:0]  symbol_count,
  input  logic [8:0]  parent_symbol_count,
  input  logic [15:0] total_freq,
  input  logic [8:0]  diff,
  input  logic [8:0]  masked_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] escape_mean,
  output int          mismatches,
  output int          awaiting
);

  localparam int SHIFT_CEIL = MAX_SHIFT_DEF;
  localparam int SHOWN_MAX  = 10;

  logic [15:0]        sums       [ENTRIES];
  logic [3:0]         shifts     [ENTRIES];
  logic [7:0]         countdowns [ENTRIES];
  logic [ENTRY_W-1:0] recent_entry;
  logic [15:0]        expected_means [$];

  // Reload every context; the last used entry is left alone.
  function automatic void load_contexts();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        sums[r*COLS+c]       = 16'((4 * r + 8) << (SHIFT_CEIL - 3));
        shifts[r*COLS+c]     = 4'(SHIFT_CEIL - 3);
        countdowns[r*COLS+c] = 8'd16;
      end
    end
  endfunction

  // Clamp diff to 1..256, then bucket diff-1 into a row.
  function automatic int unsigned row_of(input logic [8:0] d);
    int unsigned i;
    i = (d == 9'd0) ? 0 : (d > FULL_ALPHABET) ? 255 : 32'(d) - 1;
    if (i < 4) return i;
    if (i < 12) return 4 + ((i - 4) >> 1);
    if (i < 44) return 8 + ((i - 12) >> 2);
    return 16 + ((i - 44) >> 3);
  endfunction

  function automatic logic [15:0] query_mean(input logic [8:0] sc, input logic [8:0] psc,
                                             input logic [15:0] tf, input logic [8:0] d,
                                             input logic [8:0] mc);
    int unsigned col;
    int unsigned e;
    int unsigned mean;
    if (sc == FULL_ALPHABET) begin
      recent_entry = RESERVED_ENTRY;
      return 16'd1;
    end
    col = 0;
    // parent below current wraps round and always sets this bit
    if (32'(d) < 32'(psc) - 32'(sc)) col += 4;
    if (32'(tf) < 32'(TF_FACTOR) * 32'(sc)) col += 2;
    if (mc > d) col += 1;
    e = row_of(d) * COLS + col;
    recent_entry = ENTRY_W'(e);
    mean = 32'(sums[e]) >> shifts[e];
    sums[e] = sums[e] - 16'(mean);
    return (mean == 0) ? 16'd1 : 16'(mean);
  endfunction

  function automatic void adapt_recent();
    int unsigned e;
    e = recent_entry;
    if (e >= ENTRIES || shifts[e] >= SHIFT_CEIL) return;
    countdowns[e] = countdowns[e] - 8'd1;
    if (countdowns[e] != 8'd0) return;
    sums[e]       = sums[e] << 1;
    shifts[e]     = shifts[e] + 4'd1;
    countdowns[e] = 8'(32'd2 << shifts[e]);
  endfunction

  function automatic logic [15:0] predict_mean(input logic [1:0] op, input logic [8:0] sc,
                                               input logic [8:0] psc, input logic [15:0] tf,
                                               input logic [8:0] d, input logic [8:0] mc);
    case (op)
      FUNC_QUERY:  return query_mean(sc, psc, tf, d, mc);
      FUNC_UPDATE: adapt_recent();
      FUNC_REINIT: load_contexts();
      default: ;
    endcase
    return 16'd0;
  endfunction

  always @(posedge clk) begin : watch
    logic [15:0] want;
    if (rst) begin
      load_contexts();
      recent_entry = RESERVED_ENTRY;
      expected_means.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_means.push_back(predict_mean(func, symbol_count, parent_symbol_count,
                                              total_freq, diff, masked_count));
      end
      if (out_valid && !out_stall) begin
        if (expected_means.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("escape_mean %0d arrived with nothing pending", escape_mean);
        end else begin
          want = expected_means.pop_front();
          if (escape_mean !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_MAX)
              $display("escape_mean mismatch: expected %0d, got %0d", want, escape_mean);
          end
        end
      end
    end
    awaiting = expected_means.size();
  end

endmodule

### tb/tb_ppm_escape_estimator_table.sv
module tb_ppm_escape_estimator_table;
  import ppm_see_pkg::*;

  // func code that the block must treat as a no-op answering zero
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam int ITEM_TARGET = 1620;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 38;
  // full-rate stretch on both sides, counted in items
  localparam int CALM_FROM   = 900;
  localparam int CALM_TO     = 1150;
  // one long receiver hold-off so the table backs up onto its input
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LEN   = 60;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [8:0]  symbol_count;
  logic [8:0]  parent_symbol_count;
  logic [15:0] total_freq;
  logic [8:0]  diff;
  logic [8:0]  masked_count;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] escape_mean;

  int          fail_count;
  int          outstanding;
  int          items_sent = 0;
  int unsigned cycle_count = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  wire calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

  ppm_escape_estimator_table dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .func                (func),
    .symbol_count        (symbol_count),
    .parent_symbol_count (parent_symbol_count),
    .total_freq          (total_freq),
    .diff                (diff),
    .masked_count        (masked_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .escape_mean         (escape_mean)
  );

  escape_mean_checker checker_i (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .func                (func),
    .symbol_count        (symbol_count),
    .parent_symbol_count (parent_symbol_count),
    .total_freq          (total_freq),
    .diff                (diff),
    .masked_count        (masked_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .escape_mean         (escape_mean),
    .mismatches          (fail_count),
    .awaiting            (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: give up well beyond the slowest legal run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Receiver: stall at random, hold off once for a long stretch, and stay
  // quiet during the calm window. One assignment to out_stall per step.
  always @(negedge clk) begin : receiver
    logic stall_next;
    if (!hold_done && items_sent >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (rst) begin
      stall_next = 1'b0;
    end else if (hold_left > 0) begin
      stall_next = 1'b1;
      hold_left--;
    end else if (calm) begin
      stall_next = 1'b0;
    end else begin
      stall_next = ($urandom_range(99) < IDLE_PCT);
    end
    out_stall <= stall_next;
  end

  // Offer one item from a falling edge and hold it until taken; return on
  // the falling edge after acceptance so the next item can follow at once.
  task automatic offer_item(input logic [1:0] op, input logic [8:0] sc,
                            input logic [8:0] psc, input logic [15:0] tf,
                            input logic [8:0] d, input logic [8:0] mc);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    func                <= op;
    symbol_count        <= sc;
    parent_symbol_count <= psc;
    total_freq          <= tf;
    diff                <= d;
    masked_count        <= mc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [8:0]  sc;
    logic [8:0]  psc;
    logic [8:0]  d;
    logic [8:0]  mc;
    logic [15:0] tf;
    int          kind;
    int          burst;
    int          episode;

    rst                 = 1'b1;
    in_valid            = 1'b0;
    func                = FUNC_QUERY;
    symbol_count        = 9'd0;
    parent_symbol_count = 9'd0;
    total_freq          = 16'd0;
    diff                = 9'd0;
    masked_count        = 9'd0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: full alphabet takes the reserved entry; then an update on it.
    offer_item(FUNC_QUERY, 9'd256, 9'd1, 16'd0, 9'd1, 9'd0);
    offer_item(FUNC_UPDATE, 9'h1ff, 9'h1ff, 16'hffff, 9'h1ff, 9'h1ff);
    // the middle column bit alone, then every column bit together
    offer_item(FUNC_QUERY, 9'd1, 9'd1, 16'd0, 9'd1, 9'd0);
    offer_item(FUNC_QUERY, 9'd1, 9'd256, 16'd0, 9'd1, 9'd2);
    // parent smaller than current: the wrapped difference sets the top bit
    offer_item(FUNC_QUERY, 9'd10, 9'd1, 16'hffff, 9'd3, 9'd3);
    // zero diff and zero symbol count, then everything at all ones
    offer_item(FUNC_QUERY, 9'd0, 9'd0, 16'd0, 9'd0, 9'd0);
    offer_item(FUNC_QUERY, 9'h1ff, 9'h1ff, 16'hffff, 9'h1ff, 9'h1ff);
    offer_item(FUNC_QUERY, 9'd257, 9'd300, 16'd100, 9'd256, 9'd256);
    // frequency just under and at the symbol threshold
    offer_item(FUNC_QUERY, 9'd255, 9'd256, 16'd2804, 9'd4, 9'd5);
    offer_item(FUNC_QUERY, 9'd255, 9'd256, 16'd2805, 9'd4, 9'd4);
    // row bucket edges
    offer_item(FUNC_QUERY, 9'd3, 9'd40, 16'd0, 9'd5, 9'd0);
    offer_item(FUNC_QUERY, 9'd3, 9'd40, 16'd0, 9'd12, 9'd0);
    offer_item(FUNC_QUERY, 9'd3, 9'd40, 16'd0, 9'd13, 9'd0);
    offer_item(FUNC_QUERY, 9'd3, 9'd40, 16'd0, 9'd44, 9'd0);
    offer_item(FUNC_QUERY, 9'd3, 9'd40, 16'd0, 9'd45, 9'd0);
    offer_item(FUNC_SPARE, 9'h1ff, 9'h1ff, 16'hffff, 9'h1ff, 9'h1ff);
    offer_item(FUNC_UPDATE, 9'd0, 9'd0, 16'd0, 9'd0, 9'd0);
    offer_item(FUNC_UPDATE, 9'd0, 9'd0, 16'd0, 9'd0, 9'd0);
    // reload, then check the context is fresh and the last used entry kept
    offer_item(FUNC_REINIT, 9'd0, 9'd0, 16'd0, 9'd0, 9'd0);
    offer_item(FUNC_UPDATE, 9'd0, 9'd0, 16'd0, 9'd0, 9'd0);
    offer_item(FUNC_QUERY, 9'd1, 9'd1, 16'd0, 9'd1, 9'd0);

    // Random: mostly a query followed by updates on the context it chose.
    // Long update runs drive a context to its shift ceiling; drain runs
    // repeat one query to wear its mean down toward the floor of one. The rest is noise.
    episode = 0;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(99);
      sc   = ($urandom_range(9) == 0) ? 9'd256 : 9'($urandom_range(1, 255));
      psc  = 9'($urandom_range(1, 256));
      tf   = $urandom_range(1) ? 16'($urandom_range(0, 12 * sc)) : 16'($urandom);
      d    = $urandom_range(1) ? 9'($urandom_range(1, 16)) : 9'($urandom_range(1, 256));
      mc   = 9'($urandom_range(0, 256));
      if (episode == 1 || (episode > 1 && kind < 2)) begin
        repeat (DRAIN_LEN) offer_item(FUNC_QUERY, sc, psc, tf, d, mc);
      end else if (episode == 0 || kind < 80) begin
        offer_item(FUNC_QUERY, sc, psc, tf, d, mc);
        if (episode == 0) burst = 215;
        else if (kind < 3) burst = $urandom_range(150, 230);
        else burst = $urandom_range(0, 12);
        repeat (burst) begin
          offer_item(FUNC_UPDATE, 9'($urandom), 9'($urandom), 16'($urandom),
                     9'($urandom), 9'($urandom));
        end
      end else begin
        offer_item(2'($urandom_range(3)), 9'($urandom), 9'($urandom), 16'($urandom),
                   9'($urandom), 9'($urandom));
      end
      episode++;
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then a short settle.
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ppm_see_pkg.sv
rtl/ppm_see_ctrl.sv
rtl/ppm_see_dp.sv
rtl/ppm_escape_estimator_table.sv
tb/escape_mean_checker.sv
tb/tb_ppm_escape_estimator_table.sv
